// ===== design/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared constants, command/status types and counter update functions for the
// tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

	localparam int PC_INDEX_BITS_DEF    = 12;
	localparam int LOCAL_HIST_BITS_DEF  = 9;
	localparam int GLOBAL_HIST_BITS_DEF = 14;

	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_TRAIN   = 1'b1;

	typedef struct packed {
		logic clear;
		logic load_in;
		logic rd1;
		logic upd;
		logic load_out;
	} tbp_cmd_t;

	typedef struct packed {
		logic clear_last;
	} tbp_sts_t;

	function automatic logic [1:0] ctr_next(input logic [1:0] c, input logic taken);
		logic [1:0] r;
		if (!c[1]) begin
			r = taken ? 2'd0 : c + 2'd1;
		end else begin
			r = taken ? c - 2'd1 : 2'd3;
		end
		return r;
	endfunction

	function automatic logic [1:0] chooser_next(input logic [1:0] c, input logic o,
		input logic lp, input logic gp);
		logic [1:0] r;
		if (!c[1]) begin
			r = (o == lp) ? 2'd0 : c + 2'd1;
		end else begin
			r = (o == gp) ? 2'd3 : c - 2'd1;
		end
		return r;
	endfunction

endpackage

// ===== design/tbp_ram.sv =====
// ----------------------------------------------------------------------------
// tbp_ram
// Generic simple dual-port RAM: one write port, one read port with registered
// read data that holds while read enable is low.
// ----------------------------------------------------------------------------
module tbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/tbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbp_ctrl
// Controller: clearing sweep after reset, then accept / read / update / hand
// off sequence for one item at a time, and the output valid flag.
// ----------------------------------------------------------------------------
module tbp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tbp_pkg::tbp_sts_t sts,
	output tbp_pkg::tbp_cmd_t cmd
);
	import tbp_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RD1   = 3'd2;
	localparam logic [2:0] S_RD2   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_RD1;
				end
			end
			S_RD1: begin
				cmd.rd1 = 1'b1;
				state_d = S_RD2;
			end
			S_RD2: begin
				cmd.upd = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/tbp_dpath.sv =====
// ----------------------------------------------------------------------------
// tbp_dpath
// Datapath: history and counter tables, path history, clear sweep counter,
// prediction and counter update logic, output register.
// ----------------------------------------------------------------------------
module tbp_dpath #(
	parameter int PC_INDEX_BITS    = tbp_pkg::PC_INDEX_BITS_DEF,
	parameter int LOCAL_HIST_BITS  = tbp_pkg::LOCAL_HIST_BITS_DEF,
	parameter int GLOBAL_HIST_BITS = tbp_pkg::GLOBAL_HIST_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tbp_pkg::tbp_cmd_t cmd,
	output tbp_pkg::tbp_sts_t sts,
	input  logic              operation,
	input  logic [31:0]       pc,
	input  logic              outcome,
	output logic              predict_taken
);
	import tbp_pkg::*;

	localparam int MAX_LG  = (LOCAL_HIST_BITS > GLOBAL_HIST_BITS) ?
		LOCAL_HIST_BITS : GLOBAL_HIST_BITS;
	localparam int CLR_BITS = (PC_INDEX_BITS > MAX_LG) ? PC_INDEX_BITS : MAX_LG;

	logic [CLR_BITS-1:0]         clr_q;
	logic [PC_INDEX_BITS-1:0]    branch_q;
	logic                        op_q;
	logic                        outcome_q;
	logic [LOCAL_HIST_BITS-1:0]  hidx_q;
	logic [GLOBAL_HIST_BITS-1:0] phist_q;
	logic                        pred_q;
	logic                        taken_q;

	logic [LOCAL_HIST_BITS-1:0]  lht_rdata;
	logic [1:0]                  lc_rdata;
	logic [1:0]                  gc_rdata;
	logic [1:0]                  ch_rdata;

	logic                        we;
	logic [PC_INDEX_BITS-1:0]    lht_waddr;
	logic [LOCAL_HIST_BITS-1:0]  lht_wdata;
	logic [LOCAL_HIST_BITS-1:0]  lc_waddr;
	logic [GLOBAL_HIST_BITS-1:0] g_waddr;
	logic [1:0]                  lc_wdata;
	logic [1:0]                  gc_wdata;
	logic [1:0]                  ch_wdata;
	logic                        lp;
	logic                        gp;
	logic                        pred;

	assign lp   = !lc_rdata[1];
	assign gp   = !gc_rdata[1];
	assign pred = !ch_rdata[1] ? lp : gp;

	assign we        = cmd.clear || (cmd.upd && (op_q == OP_TRAIN));
	assign lht_waddr = cmd.clear ? clr_q[PC_INDEX_BITS-1:0] : branch_q;
	assign lc_waddr  = cmd.clear ? clr_q[LOCAL_HIST_BITS-1:0] : hidx_q;
	assign g_waddr   = cmd.clear ? clr_q[GLOBAL_HIST_BITS-1:0] : phist_q;
	assign lht_wdata = cmd.clear ? '0 : {hidx_q[LOCAL_HIST_BITS-2:0], outcome_q};
	assign lc_wdata  = cmd.clear ? 2'd0 : ctr_next(lc_rdata, outcome_q);
	assign gc_wdata  = cmd.clear ? 2'd0 : ctr_next(gc_rdata, outcome_q);
	assign ch_wdata  = cmd.clear ? 2'd0 : chooser_next(ch_rdata, outcome_q, lp, gp);

	assign sts.clear_last = &clr_q;

	tbp_ram #(.WIDTH(LOCAL_HIST_BITS), .DEPTH(2 ** PC_INDEX_BITS)) u_lht (
		.clk   (clk),
		.we    (we),
		.waddr (lht_waddr),
		.wdata (lht_wdata),
		.re    (cmd.load_in),
		.raddr (pc[PC_INDEX_BITS-1:0]),
		.rdata (lht_rdata)
	);

	tbp_ram #(.WIDTH(2), .DEPTH(2 ** LOCAL_HIST_BITS)) u_lc (
		.clk   (clk),
		.we    (we),
		.waddr (lc_waddr),
		.wdata (lc_wdata),
		.re    (cmd.rd1),
		.raddr (lht_rdata),
		.rdata (lc_rdata)
	);

	tbp_ram #(.WIDTH(2), .DEPTH(2 ** GLOBAL_HIST_BITS)) u_gc (
		.clk   (clk),
		.we    (we),
		.waddr (g_waddr),
		.wdata (gc_wdata),
		.re    (cmd.load_in),
		.raddr (phist_q),
		.rdata (gc_rdata)
	);

	tbp_ram #(.WIDTH(2), .DEPTH(2 ** GLOBAL_HIST_BITS)) u_ch (
		.clk   (clk),
		.we    (we),
		.waddr (g_waddr),
		.wdata (ch_wdata),
		.re    (cmd.load_in),
		.raddr (phist_q),
		.rdata (ch_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			phist_q <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.upd && (op_q == OP_TRAIN)) begin
				phist_q <= {phist_q[GLOBAL_HIST_BITS-2:0], outcome_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			branch_q  <= pc[PC_INDEX_BITS-1:0];
			op_q      <= operation;
			outcome_q <= outcome;
		end
		if (cmd.rd1) begin
			hidx_q <= lht_rdata;
		end
		if (cmd.upd) begin
			pred_q <= pred;
		end
		if (cmd.load_out) begin
			taken_q <= pred_q;
		end
	end

	assign predict_taken = taken_q;

endmodule

// ===== design/tournament_branch_predictor_unit.sv =====
// predict_taken is registered; after the input transfer the item passes RD1,
// RD2 and DONE, and DONE holds until the output slot is free. One item is in
// flight at a time; the local history and then local counter tables are read
// in turn through registered RAM ports. Reset: arst_n clears control and path
// history, then a sweep over every address of the largest table zeroes all
// tables; in_ready stays low until it ends.
// ----------------------------------------------------------------------------
// tournament_branch_predictor_unit
// Tournament branch predictor: local history, global path history and a
// chooser table; predicts, and trains all three counters on train requests.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_unit #(
	parameter int PC_INDEX_BITS    = tbp_pkg::PC_INDEX_BITS_DEF,
	parameter int LOCAL_HIST_BITS  = tbp_pkg::LOCAL_HIST_BITS_DEF,
	parameter int GLOBAL_HIST_BITS = tbp_pkg::GLOBAL_HIST_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] pc,
	input  logic        outcome,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        predict_taken
);
	import tbp_pkg::*;

	tbp_cmd_t cmd;
	tbp_sts_t sts;

	tbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tbp_dpath #(
		.PC_INDEX_BITS    (PC_INDEX_BITS),
		.LOCAL_HIST_BITS  (LOCAL_HIST_BITS),
		.GLOBAL_HIST_BITS (GLOBAL_HIST_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.pc            (pc),
		.outcome       (outcome),
		.predict_taken (predict_taken)
	);

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.clear)
		else $error("input ready during table clear");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.load_in, cmd.rd1, cmd.upd, cmd.load_out}))
		else $error("more than one controller command active");

	a_read_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> cmd.rd1 ##1 cmd.upd)
		else $error("table read sequence broken");

	a_hold_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> !in_ready)
		else $error("new transfer taken before result handed off");

endmodule

// ===== bench/tb_tournament_branch_predictor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tournament_branch_predictor_unit
// Drives predict and train transfers into the tournament branch predictor and
// keeps a shadow copy of its history and counter tables. Every prediction
// that comes back is checked, in order, against the one computed before the
// matching train update. Both handshakes idle in random bursts until the
// final stretch of the run.
// ----------------------------------------------------------------------------
module tb_tournament_branch_predictor_unit;

	localparam int RANDOM_ITEMS = 1250;
	localparam int QUIET_ITEMS  = 150;
	localparam int POOL_SIZE    = 8;
	localparam int HIGH_BITS    = 32 - tbp_pkg::PC_INDEX_BITS_DEF;

	typedef enum int {
		PAT_TAKEN,
		PAT_NOT_TAKEN,
		PAT_ALTERNATE,
		PAT_LOOP3,
		PAT_LOOP5,
		PAT_NOISE
	} pattern_t;

	class tbp_scoreboard;
		localparam int PCB = tbp_pkg::PC_INDEX_BITS_DEF;
		localparam int LHB = tbp_pkg::LOCAL_HIST_BITS_DEF;
		localparam int GHB = tbp_pkg::GLOBAL_HIST_BITS_DEF;
		localparam logic [1:0] CTR_STRONG_T  = 2'd0;
		localparam logic [1:0] CTR_WEAK_NT   = 2'd2;
		localparam logic [1:0] CTR_STRONG_NT = 2'd3;

		logic [LHB-1:0] branch_hist [1 << PCB];
		logic [1:0]     pattern_ctr [1 << LHB];
		logic [1:0]     path_ctr [1 << GHB];
		logic [1:0]     select_ctr [1 << GHB];
		logic [GHB-1:0] path_hist;
		logic           predictions [$];

		function new();
			foreach (branch_hist[i]) branch_hist[i] = '0;
			foreach (pattern_ctr[i]) pattern_ctr[i] = CTR_STRONG_T;
			foreach (path_ctr[i]) path_ctr[i] = CTR_STRONG_T;
			foreach (select_ctr[i]) select_ctr[i] = CTR_STRONG_T;
			path_hist = '0;
		endfunction

		function logic [1:0] bump(input logic [1:0] c, input logic taken);
			if (c < CTR_WEAK_NT) begin
				return taken ? CTR_STRONG_T : c + 2'd1;
			end
			return taken ? c - 2'd1 : CTR_STRONG_NT;
		endfunction

		function logic [1:0] bump_select(input logic [1:0] c, input logic dir,
			input logic lp, input logic gp);
			if (c < CTR_WEAK_NT) begin
				return (dir == lp) ? CTR_STRONG_T : c + 2'd1;
			end
			return (dir == gp) ? CTR_STRONG_NT : c - 2'd1;
		endfunction

		function void note_transfer(input logic op, input logic [31:0] addr,
			input logic dir);
			logic [PCB-1:0] slot;
			logic [LHB-1:0] hidx;
			logic [GHB-1:0] gidx;
			logic lp;
			logic gp;
			slot = addr[PCB-1:0];
			hidx = branch_hist[slot];
			gidx = path_hist;
			lp = pattern_ctr[hidx] < CTR_WEAK_NT;
			gp = path_ctr[gidx] < CTR_WEAK_NT;
			predictions.push_back((select_ctr[gidx] < CTR_WEAK_NT) ? lp : gp);
			if (op == tbp_pkg::OP_TRAIN) begin
				select_ctr[gidx] = bump_select(select_ctr[gidx], dir, lp, gp);
				path_ctr[gidx] = bump(path_ctr[gidx], dir);
				pattern_ctr[hidx] = bump(pattern_ctr[hidx], dir);
				branch_hist[slot] = {hidx[LHB-2:0], dir};
				path_hist = {gidx[GHB-2:0], dir};
			end
		endfunction

		function bit check_prediction(input logic got, output string msg);
			logic want;
			msg = "";
			if (predictions.size() == 0) begin
				msg = $sformatf("prediction %b with none pending", got);
				return 0;
			end
			want = predictions.pop_front();
			if (got !== want) begin
				msg = $sformatf("predict_taken got %b want %b", got, want);
				return 0;
			end
			return 1;
		endfunction

		function int pending();
			return predictions.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = tbp_pkg::OP_PREDICT;
	logic [31:0] pc = '0;
	logic        outcome = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        predict_taken;

	tbp_scoreboard sb;
	int            errors = 0;
	bit            quiet = 1'b0;
	int            hold_left = 0;
	string         note;

	logic [31:0] pool_pc [POOL_SIZE];
	pattern_t    pool_pat [POOL_SIZE];
	int          pool_step [POOL_SIZE];

	tournament_branch_predictor_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.pc           (pc),
		.outcome      (outcome),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.predict_taken(predict_taken)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic push_branch(input logic op, input logic [31:0] addr, input logic dir);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pc <= addr;
		outcome <= dir;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_transfer(op, addr, dir);
	endtask

	function automatic logic pool_outcome(input int k);
		int s;
		s = pool_step[k];
		case (pool_pat[k])
			PAT_TAKEN:     return 1'b1;
			PAT_NOT_TAKEN: return 1'b0;
			PAT_ALTERNATE: return s[0];
			PAT_LOOP3:     return (s % 3) != 2;
			PAT_LOOP5:     return (s % 5) != 4;
			default:       return 1'($urandom_range(0, 1));
		endcase
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (!sb.check_prediction(predict_taken, note)) begin
				report_mismatch(note);
			end
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			hold_left <= $urandom_range(0, 9);
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		int k;
		logic op;
		logic [31:0] addr;
		logic dir;
		sb = new();
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_pc[i] = $urandom;
			pool_pat[i] = pattern_t'(i % 6);
			pool_step[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// cleared tables, pc extremes, ignored outcome on predict
		push_branch(tbp_pkg::OP_PREDICT, 32'h0000_0000, 1'b0);
		push_branch(tbp_pkg::OP_PREDICT, 32'hFFFF_FFFF, 1'b1);
		push_branch(tbp_pkg::OP_TRAIN, 32'h0000_0000, 1'b0);
		push_branch(tbp_pkg::OP_TRAIN, 32'h0000_0000, 1'b0);
		push_branch(tbp_pkg::OP_TRAIN, 32'h0000_0000, 1'b0);
		push_branch(tbp_pkg::OP_PREDICT, 32'h0000_0000, 1'b1);
		push_branch(tbp_pkg::OP_PREDICT, 32'h0000_0000, 1'b0);
		// aliasing through the high pc bits
		push_branch(tbp_pkg::OP_TRAIN, 32'h1234_5ABC, 1'b1);
		push_branch(tbp_pkg::OP_PREDICT, 32'hFEDC_BABC, 1'b0);
		push_branch(tbp_pkg::OP_TRAIN, 32'hFFFF_F000, 1'b1);
		// overflow the local history of one branch
		for (int i = 0; i < 12; i++) begin
			push_branch(tbp_pkg::OP_TRAIN, 32'h0000_0FFF, (i % 3) != 0);
		end
		push_branch(tbp_pkg::OP_PREDICT, 32'hAAAA_AFFF, 1'b0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
				quiet = 1'b1;
			end
			op = ($urandom_range(0, 4) != 0) ? tbp_pkg::OP_TRAIN : tbp_pkg::OP_PREDICT;
			if ($urandom_range(0, 9) < 7) begin
				k = $urandom_range(0, POOL_SIZE - 1);
				addr = pool_pc[k];
				if ($urandom_range(0, 7) == 0) begin
					addr[31:tbp_pkg::PC_INDEX_BITS_DEF] = HIGH_BITS'($urandom);
				end
				dir = pool_outcome(k);
				if (op == tbp_pkg::OP_TRAIN) begin
					pool_step[k]++;
				end
			end else begin
				addr = $urandom;
				dir = 1'($urandom_range(0, 1));
			end
			push_branch(op, addr, dir);
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.pending() != 0) begin
			report_mismatch($sformatf("%0d predictions never arrived", sb.pending()));
		end
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
